FILE: design/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types and constants for the linear blend vertex skinning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lbvs_pkg;
  localparam int ELEMS_PER_BONE = 12;
  localparam int INFL_FIELDS    = 4;
  localparam int BONE_W         = 6;
  localparam int WEIGHT_W       = 17;
  localparam int COORD_W        = 32;
  localparam int MID_W          = 47;
  localparam int ACC_W          = 53;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_SKIN  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MID_W-1:0]   mid_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  function automatic logic signed [63:0] clamp_mid(input logic signed [63:0] v,
                                                    output logic sat);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi  = (64'sd1 <<< (MID_W-1)) - 64'sd1;
      lo  = -(64'sd1 <<< (MID_W-1));
      sat = 1'b0;
      clamp_mid = v;
      if (v > hi) begin
        clamp_mid = hi;
        sat = 1'b1;
      end else if (v < lo) begin
        clamp_mid = lo;
        sat = 1'b1;
      end
    end
  endfunction
endpackage
`default_nettype wire

FILE: design/linear_blend_vertex_skinning_top.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// Four-bone linear blend skinning with a 3x4 Q16.16 bone palette per lane.
// ----------------------------------------------------------------------------
// One vertex is taken per cycle unless the chain stalls or the palette clears.
// The pipeline is a stall-all chain: everything advances when the output
// register is empty or being taken. Palette writes produce no result.
// Reset clears control; the palette clears by a sweep over every word
// (one word per cycle into every lane copy) during which in_tready is low.
`timescale 1ns / 1ps
`default_nettype none
module linear_blend_vertex_skinning_top #(
  parameter int NUM_BONES      = 64,
  parameter int MAX_INFLUENCES = 4
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, pos_z, bone_0..3, weight_0..3, zero pad
  input  wire [199:0]  in_tdata,
  // action
  input  wire          in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // out_x, out_y, out_z
  output logic [95:0]  out_tdata,
  // saturated
  output logic         out_tuser
);
  import lbvs_pkg::*;
  localparam int LANES = (MAX_INFLUENCES < INFL_FIELDS) ? MAX_INFLUENCES : INFL_FIELDS;
  localparam int WORDS = NUM_BONES * ELEMS_PER_BONE;
  localparam int CW    = $clog2(WORDS + 1);
  localparam int RW    = $clog2(NUM_BONES * 3 + 1);
  localparam int DEPTH = 4;

  logic [CW-1:0]   clr_r, clr_nxt;
  logic            clearing;
  logic            adv;
  logic [DEPTH-1:0] vld_r;
  logic            ovld_r;
  logic            take;
  logic            wr_en;
  logic [RW-1:0]   wr_row;
  logic [1:0]      wr_col;
  logic [31:0]     wr_data;
  logic [BONE_W-1:0] wb;
  logic [5:0]      we;
  logic [LANES-1:0] use_v;
  acc_t            lx [LANES];
  acc_t            ly [LANES];
  acc_t            lz [LANES];
  logic [LANES-1:0] lsat;
  logic [95:0]     mpos;
  logic            msat;

  assign clearing = (clr_r != CW'(WORDS));
  assign clr_nxt  = clearing ? clr_r + CW'(1) : clr_r;
  assign adv      = !ovld_r || out_tready;
  assign in_tready = adv && !clearing;
  assign take     = in_tvalid && in_tready;

  assign wb = in_tdata[101:96];
  assign we = in_tdata[107:102];
  always_comb begin
    logic [RW+BONE_W:0] rr;
    rr = (RW+BONE_W+1)'(wb) * (RW+BONE_W+1)'(3) + (RW+BONE_W+1)'(we[3:2]);
    if (clearing) begin
      wr_en   = 1'b1;
      wr_row  = RW'(clr_r >> 2);
      wr_col  = clr_r[1:0];
      wr_data = '0;
    end else begin
      wr_en   = take && (in_tuser == ACT_WRITE) &&
                ({3'b0, wb} < (BONE_W+3)'(NUM_BONES)) && (we < 6'(ELEMS_PER_BONE));
      wr_row  = rr[RW-1:0];
      wr_col  = we[1:0];
      wr_data = in_tdata[31:0];
    end
  end

  always_comb begin
    logic stop;
    stop = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (in_tdata[120 + l*17 +: 17] == '0) stop = 1'b1;
      use_v[l] = !stop;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lbvs_lane #(.NUM_BONES(NUM_BONES)) u_lane (
      .clk, .rst_n, .wr_en, .wr_row, .wr_col, .wr_data,
      .s0_en(1'b1),
      .s0_use(use_v[l] && take && (in_tuser == ACT_SKIN)),
      .s0_bone(in_tdata[96 + l*6 +: 6]),
      .s0_weight(in_tdata[120 + l*17 +: 17]),
      .s0_pos(in_tdata[95:0]),
      .adv,
      .res_x(lx[l]), .res_y(ly[l]), .res_z(lz[l]), .res_sat(lsat[l])
    );
  end

  lbvs_merge #(.LANES(LANES)) u_merge (
    .clk, .adv, .lx, .ly, .lz, .lsat, .pos(mpos), .sat(msat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      clr_r <= clr_nxt;
      if (adv) begin
        vld_r  <= {vld_r[DEPTH-2:0], take && (in_tuser == ACT_SKIN)};
        ovld_r <= vld_r[DEPTH-1];
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = mpos;
  assign out_tuser  = msat;
endmodule
`default_nettype wire

FILE: design/lbvs_palette.sv
// ----------------------------------------------------------------------------
// lbvs_palette
// Palette memory for one lane; one matrix element per word, 4 words per row.
// Row read is registered. Clearing pass after reset sweeps every row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lbvs_palette #(
  parameter int NUM_BONES = 64
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire [$clog2(NUM_BONES*3+1)-1:0] wr_row,
  input  wire [1:0]                  wr_col,
  input  wire [31:0]                 wr_data,
  input  wire                        rd_en,
  input  wire [$clog2(NUM_BONES*3+1)-1:0] rd_row,
  output logic [127:0]               rd_data
);
  import lbvs_pkg::*;
  localparam int ROWS = NUM_BONES * 3;
  localparam int RW   = $clog2(ROWS + 1);

  logic [31:0] mem0 [ROWS];
  logic [31:0] mem1 [ROWS];
  logic [31:0] mem2 [ROWS];
  logic [31:0] mem3 [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en && wr_row < RW'(ROWS)) begin
      case (wr_col)
        2'd0:    mem0[wr_row] <= wr_data;
        2'd1:    mem1[wr_row] <= wr_data;
        2'd2:    mem2[wr_row] <= wr_data;
        default: mem3[wr_row] <= wr_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_row < RW'(ROWS)) begin
        rd_data <= {mem3[rd_row], mem2[rd_row], mem1[rd_row], mem0[rd_row]};
      end else begin
        rd_data <= '0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/lbvs_lane.sv
// ----------------------------------------------------------------------------
// lbvs_lane
// One influence lane: reads the bone rows, transforms the point, clamps to
// 47 bits and weights it. Three row units work side by side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lbvs_lane #(
  parameter int NUM_BONES = 64
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         wr_en,
  input  wire [$clog2(NUM_BONES*3+1)-1:0] wr_row,
  input  wire [1:0]                   wr_col,
  input  wire [31:0]                  wr_data,
  input  wire                         s0_en,
  input  wire                         s0_use,
  input  wire [lbvs_pkg::BONE_W-1:0]  s0_bone,
  input  wire [lbvs_pkg::WEIGHT_W-1:0] s0_weight,
  input  wire [95:0]                  s0_pos,
  input  wire                         adv,
  output lbvs_pkg::acc_t              res_x,
  output lbvs_pkg::acc_t              res_y,
  output lbvs_pkg::acc_t              res_z,
  output logic                        res_sat
);
  import lbvs_pkg::*;
  localparam int RW = $clog2(NUM_BONES * 3 + 1);

  logic [127:0]       row_d [3];
  logic               use1_r, use1_nxt;
  logic [WEIGHT_W-1:0] w1_r, w2_r, w3_r;
  logic               use2_r, use3_r;
  logic [95:0]        pos1_r;
  logic signed [63:0] prod_r [3][3];
  logic signed [31:0] tr_r [3];
  mid_t               mid_r [3];
  logic [2:0]         sat3_r;
  acc_t               out_r [3];
  logic               sat4_r;
  logic               oor;

  assign oor = ({3'b0, s0_bone} >= (BONE_W+3)'(NUM_BONES));
  assign use1_nxt = s0_use && !oor;

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic [RW-1:0] rd_row;
    logic [RW+BONE_W:0] calc;
    assign calc   = (RW+BONE_W+1)'(s0_bone) * (RW+BONE_W+1)'(3) + (RW+BONE_W+1)'(r);
    assign rd_row = oor ? RW'(NUM_BONES * 3) : calc[RW-1:0];
    lbvs_palette #(.NUM_BONES(NUM_BONES)) u_pal (
      .clk, .wr_en, .wr_row, .wr_col, .wr_data,
      .rd_en(adv), .rd_row, .rd_data(row_d[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use1_r <= 1'b0;
      use2_r <= 1'b0;
      use3_r <= 1'b0;
    end else if (adv) begin
      if (s0_en) begin
        use1_r <= use1_nxt;
      end
      use2_r <= use1_r;
      use3_r <= use2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] s;
    logic               sa;
    logic signed [63:0] cm;
    logic signed [63:0] pw;
    if (adv) begin
      if (s0_en) begin
        w1_r   <= s0_weight;
        pos1_r <= s0_pos;
      end
      w2_r   <= w1_r;
      w3_r   <= w2_r;
      for (int r = 0; r < 3; r++) begin
        tr_r[r] <= row_d[r][127:96];
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= 64'(signed'(row_d[r][c*32 +: 32])) *
                          64'(signed'(pos1_r[c*32 +: 32]));
        end
      end
      for (int r = 0; r < 3; r++) begin
        s = 64'(tr_r[r]) + (prod_r[r][0] >>> 16) + (prod_r[r][1] >>> 16) +
            (prod_r[r][2] >>> 16);
        cm = clamp_mid(s, sa);
        mid_r[r]  <= cm[MID_W-1:0];
        sat3_r[r] <= sa && use2_r;
      end
      for (int r = 0; r < 3; r++) begin
        pw = 64'(mid_r[r]) * 64'(signed'({1'b0, w3_r}));
        out_r[r] <= use3_r ? ACC_W'(pw >>> 16) : '0;
      end
      sat4_r <= use3_r && (|sat3_r);
    end
  end

  assign res_x   = out_r[0];
  assign res_y   = out_r[1];
  assign res_z   = out_r[2];
  assign res_sat = sat4_r;
endmodule
`default_nettype wire

FILE: design/lbvs_merge.sv
// ----------------------------------------------------------------------------
// lbvs_merge
// Sums the lane results and saturates each coordinate to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lbvs_merge #(
  parameter int LANES = 4
) (
  input  wire                 clk,
  input  wire                 adv,
  input  wire lbvs_pkg::acc_t lx [LANES],
  input  wire lbvs_pkg::acc_t ly [LANES],
  input  wire lbvs_pkg::acc_t lz [LANES],
  input  wire [LANES-1:0]     lsat,
  output logic [95:0]         pos,
  output logic                sat
);
  import lbvs_pkg::*;
  logic signed [ACC_W+3:0] sx, sy, sz;
  logic [95:0]             pos_r;
  logic                    sat_r;

  function automatic logic [31:0] clamp32(input logic signed [ACC_W+3:0] v,
                                          output logic s);
    begin
      s = 1'b0;
      clamp32 = v[31:0];
      if (v > (ACC_W+4)'(signed'(32'sh7fffffff))) begin
        clamp32 = 32'h7fffffff;
        s = 1'b1;
      end else if (v < (ACC_W+4)'(signed'(32'sh80000000))) begin
        clamp32 = 32'h80000000;
        s = 1'b1;
      end
    end
  endfunction

  always_comb begin
    sx = '0;
    sy = '0;
    sz = '0;
    for (int l = 0; l < LANES; l++) begin
      sx = sx + (ACC_W+4)'(lx[l]);
      sy = sy + (ACC_W+4)'(ly[l]);
      sz = sz + (ACC_W+4)'(lz[l]);
    end
  end

  always_ff @(posedge clk) begin
    logic a, b, c;
    if (adv) begin
      pos_r[31:0]  <= clamp32(sx, a);
      pos_r[63:32] <= clamp32(sy, b);
      pos_r[95:64] <= clamp32(sz, c);
      sat_r        <= a | b | c | (|lsat);
    end
  end

  assign pos = pos_r;
  assign sat = sat_r;
endmodule
`default_nettype wire

FILE: design/lbvs_checker.sv
// ----------------------------------------------------------------------------
// lbvs_checker
// Port-level checks on the skinning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lbvs_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [95:0]  out_tdata,
  input wire         out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  a_clr: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during palette clear");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind linear_blend_vertex_skinning_top lbvs_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the four-bone linear blend skinning block. A local
// palette model predicts each skinned vertex; results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import lbvs_pkg::*;

  localparam int NBONES = 64;
  localparam int NINFL  = 4;
  localparam logic signed [63:0] MIDHI = (64'sd1 <<< 46) - 64'sd1;
  localparam logic signed [63:0] MIDLO = -(64'sd1 <<< 46);
  localparam logic signed [63:0] OHI = 64'sd2147483647;
  localparam logic signed [63:0] OLO = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] x, y, z;
    logic        sat;
  } skin_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [199:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic out_tuser;

  int src_idle = 0;
  int snk_idle = 0;
  int errors = 0;
  logic [31:0] palette [NBONES*12];
  skin_res_t skin_q[$];

  linear_blend_vertex_skinning_top #(.NUM_BONES(NBONES), .MAX_INFLUENCES(NINFL)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [63:0] clampv(input logic signed [63:0] v,
      input logic signed [63:0] lo, input logic signed [63:0] hi, inout logic s);
    if (v > hi) begin
      s = 1'b1;
      return hi;
    end
    if (v < lo) begin
      s = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic skin_res_t skin_vertex(input logic [199:0] d);
    logic signed [63:0] pos [3];
    logic signed [63:0] acc [3];
    logic signed [63:0] p;
    logic signed [63:0] w;
    logic [5:0] bone;
    logic s;
    skin_res_t r;
    s = 1'b0;
    for (int c = 0; c < 3; c++) begin
      pos[c] = $signed(d[32*c +: 32]);
      acc[c] = 0;
    end
    for (int j = 0; j < NINFL; j++) begin
      bone = d[96 + 6*j +: 6];
      w = {47'd0, d[120 + 17*j +: 17]};
      if (w == 0) break;
      if (bone >= NBONES) continue;
      for (int rr = 0; rr < 3; rr++) begin
        p = $signed(palette[bone*12 + rr*4 + 3]);
        for (int c = 0; c < 3; c++)
          p += ($signed(palette[bone*12 + rr*4 + c]) * pos[c]) >>> 16;
        p = clampv(p, MIDLO, MIDHI, s);
        acc[rr] += (p * w) >>> 16;
      end
    end
    r.x = 32'(clampv(acc[0], OLO, OHI, s));
    r.y = 32'(clampv(acc[1], OLO, OHI, s));
    r.z = 32'(clampv(acc[2], OLO, OHI, s));
    r.sat = s;
    return r;
  endfunction

  task automatic send_item(input logic act, input logic [199:0] d);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    if (act == ACT_SKIN) begin
      skin_q = {skin_q, skin_vertex(d)};
    end else if (d[96 +: 6] < NBONES && d[102 +: 6] < ELEMS_PER_BONE) begin
      palette[d[96 +: 6]*12 + d[102 +: 6]] = d[31:0];
    end
  endtask

  function automatic logic [199:0] pack_vertex(input logic [31:0] x, y, z,
      input logic [23:0] bones, input logic [67:0] wts);
    return {12'd0, wts, bones, z, y, x};
  endfunction

  task automatic write_elem(input int bone, input int elem, input logic [31:0] v);
    send_item(ACT_WRITE, {12'd0, 68'd0, 12'd0, 6'(elem), 6'(bone), 64'd0, v});
  endtask

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(4))
      0: return 32'h0001_0000;
      1: return $urandom;
      2: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed(32'($urandom_range(262144))) - 32'sd131072;
    endcase
  endfunction

  function automatic logic [16:0] rnd_weight();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1FFFF;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [199:0] rnd_vertex();
    logic [23:0] b;
    logic [67:0] w;
    for (int j = 0; j < 4; j++) begin
      b[6*j +: 6] = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      w[17*j +: 17] = rnd_weight();
    end
    return pack_vertex(rnd_elem(), rnd_elem(), rnd_elem(), b, w);
  endfunction

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (skin_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= (snk_idle == 0) || ($urandom_range(99) >= snk_idle);
    if (rst_n && out_tvalid && out_tready) begin
      if (skin_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        skin_res_t e;
        e = skin_q.pop_front();
        if (out_tdata[31:0] !== e.x) begin
          $error("out_x exp %h got %h", e.x, out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== e.y) begin
          $error("out_y exp %h got %h", e.y, out_tdata[63:32]); errors++;
        end
        if (out_tdata[95:64] !== e.z) begin
          $error("out_z exp %h got %h", e.z, out_tdata[95:64]); errors++;
        end
        if (out_tuser !== e.sat) begin
          $error("saturated exp %b got %b", e.sat, out_tuser); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // empty list, reset palette, identity, extremes, out-of-range writes
    send_item(ACT_SKIN, pack_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 24'd0, 68'd0));
    send_item(ACT_SKIN, pack_vertex(32'd5, 32'd6, 32'd7, 24'd0,
              {17'd1, 17'd1, 17'd1, 17'd65536}));
    for (int r = 0; r < 3; r++) write_elem(0, r*5, 32'h0001_0000);
    write_elem(0, 3, 32'h0002_0000);
    write_elem(63, 0, 32'h7FFF_FFFF);
    write_elem(63, 11, 32'h8000_0000);
    write_elem(1, 12, 32'hDEAD_BEEF);
    write_elem(1, 63, 32'hDEAD_BEEF);
    send_item(ACT_SKIN, pack_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
              24'd0, {51'd0, 17'd65536}));
    send_item(ACT_SKIN, pack_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              {6'd0, 6'd63, 6'd0, 6'd63}, {4{17'h1FFFF}}));
    send_item(ACT_SKIN, pack_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              {6'd63, 6'd0, 6'd63, 6'd0}, {4{17'h1FFFF}}));
    // zero weight in the middle ends the list
    send_item(ACT_SKIN, pack_vertex(32'd3, 32'd4, 32'd5, {6'd63, 6'd63, 6'd0, 6'd0},
              {17'd65536, 17'd65536, 17'd0, 17'd32768}));
    // the last bone in the palette is used and does not end the list
    write_elem(0, 7, 32'hFFFF_FFFF);
    send_item(ACT_SKIN, pack_vertex(32'hFFFF_FFFF, 32'd0, 32'd0,
              {6'd63, 6'd0, 6'd0, 6'd0}, {17'd65536, 17'd65536, 17'd1, 17'd3}));
    wait_drain();
  endtask

  task automatic test_random(input int n);
    logic [223:0] raw;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        write_elem($urandom_range(63), $urandom_range(11), rnd_elem());
      else if ($urandom_range(49) == 0) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        send_item(ACT_WRITE, raw[199:0]);
      end else
        send_item(ACT_SKIN, rnd_vertex());
      if (i == n/2) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    foreach (palette[i]) palette[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    src_idle = 38; snk_idle = 77;
    test_random(620);
    src_idle = 77; snk_idle = 38;
    test_random(620);
    src_idle = 0; snk_idle = 0;
    test_random(620);
    repeat (20) @(posedge clk);
    if (errors == 0 && skin_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
